@@ hw/rtl/bpa_pkg.sv @@
// Shared constants, codes and types of the bitmap page allocator.
package bpa_pkg;

  localparam int MAX_PAGES  = 4096;
  // Page size must be a power of two; the page index is a shift of the offset.
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = 5;
  localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int PIDX_W     = WADDR_W + BIT_W;
  localparam int LIVE_W     = $clog2(MAX_PAGES + 1);

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 13;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int PCFG_W     = 13;
  localparam int PADDR_W    = 4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_END   = 2'd1,
    REG_PAGES = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] end_addr;
    logic [PCFG_W-1:0] page_count;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [WADDR_W-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [WADDR_W-1:0]   raddr;
  } mem_req_t;

endpackage

@@ hw/rtl/bpa_if.sv @@
// Request and result channel interfaces of the bitmap page allocator.
interface bpa_in_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output action, output address, input ready);
  modport sink (input valid, input action, input address, output ready);
endinterface

interface bpa_out_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] page_address;
  status_t           status;
  logic [CNT_W-1:0]  pages_in_use;

  modport source (output valid, output page_address, output status, output pages_in_use,
                  input ready);
  modport sink (input valid, input page_address, input status, input pages_in_use,
                output ready);
endinterface

@@ hw/rtl/bpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bpa_cfg.sv @@
// APB register file holding the managed range and the page count.
module bpa_cfg import bpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_BASE:  cfg_r.base_addr  <= pwdata;
        REG_END:   cfg_r.end_addr   <= pwdata;
        REG_PAGES: cfg_r.page_count <= pwdata[PCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BASE:  prdata = cfg_r.base_addr;
      REG_END:   prdata = cfg_r.end_addr;
      REG_PAGES: prdata = {{(32-PCFG_W){1'b0}}, cfg_r.page_count};
      default:   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
// Request sequencer: bitmap word scan, read-modify-write, used count and result register.
module bpa_ctrl import bpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  bpa_in_if.sink               in_if,
  bpa_out_if.source            out_if,
  output mem_req_t             mem_req,
  input  logic [WORD_BITS-1:0] mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FREE,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic                act_r, act_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [WADDR_W-1:0]  wa_r, wa_nxt;
  logic [WADDR_W-1:0]  lastw_r, lastw_nxt;
  logic [BIT_W-1:0]    tail_r, tail_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic                rv_q_r;
  logic [WORD_COUNT-1:0] row_valid_r, row_valid_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   res_paddr_r, res_paddr_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]   out_paddr_r, out_paddr_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [CNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic [LIVE_W-1:0]    live_n;
  logic [LIVE_W-1:0]    live_m1;
  logic [ADDR_W-1:0]    offset;
  logic [ADDR_W-1:0]    idx32;
  logic                 out_of_range;
  logic [WORD_BITS-1:0] word_eff;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] cand;
  logic                 found;
  logic [BIT_W-1:0]     fbit;
  logic [PIDX_W-1:0]    pidx;
  logic [ADDR_W-1:0]    alloc_paddr;

  // Page counts above the bitmap size act as the bitmap size.
  assign live_n  = (32'(cfg.page_count) > 32'(MAX_PAGES)) ? LIVE_W'(MAX_PAGES)
                                                           : LIVE_W'(cfg.page_count);
  assign live_m1 = live_n - LIVE_W'(1);

  assign offset       = addr_r - cfg.base_addr;
  assign idx32        = offset >> PAGE_SHIFT;
  assign out_of_range = (addr_r > cfg.end_addr) || (addr_r < cfg.base_addr) ||
                        (idx32 >= 32'(live_n));

  // A row never written since reset reads as all pages free.
  assign word_eff = rv_q_r ? mem_rdata : '0;
  assign mask     = ((wa_r == lastw_r) && (tail_r != '0))
                    ? ((WORD_BITS'(1) << tail_r) - WORD_BITS'(1)) : '1;
  assign cand     = ~word_eff & mask;
  assign found    = |cand;

  always_comb begin
    fbit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        fbit = BIT_W'(i);
      end
    end
  end

  assign pidx        = {wa_r, fbit};
  assign alloc_paddr = cfg.base_addr + (ADDR_W'(pidx) << PAGE_SHIFT);

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = wa_r;
    mem_req.wdata = word_eff & ~(WORD_BITS'(1) << bit_r);
    mem_req.raddr = wa_r;
    case (state_r)
      S_CHECK: begin
        if (act_r == ACT_ALLOC) begin
          mem_req.raddr = '0;
        end else begin
          mem_req.raddr = WADDR_W'(idx32 >> BIT_W);
        end
      end
      S_SCAN: begin
        mem_req.raddr = (wa_r == lastw_r) ? wa_r : wa_r + WADDR_W'(1);
        mem_req.we    = found;
        mem_req.wdata = word_eff | (WORD_BITS'(1) << fbit);
      end
      S_FREE: begin
        mem_req.we = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    addr_nxt       = addr_r;
    wa_nxt         = wa_r;
    lastw_nxt      = lastw_r;
    tail_nxt       = tail_r;
    bit_nxt        = bit_r;
    row_valid_nxt  = row_valid_r;
    cnt_nxt        = cnt_r;
    res_paddr_nxt  = res_paddr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_paddr_nxt  = out_paddr_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;

    if (mem_req.we) begin
      row_valid_nxt[mem_req.waddr] = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          act_nxt   = in_if.action;
          addr_nxt  = in_if.address;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_paddr_nxt  = '0;
        res_status_nxt = ST_DONE;
        lastw_nxt      = WADDR_W'(live_m1 >> BIT_W);
        tail_nxt       = BIT_W'(live_n);
        if (act_r == ACT_ALLOC) begin
          wa_nxt = '0;
          if (live_n == '0) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end else if (out_of_range) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          wa_nxt    = WADDR_W'(idx32 >> BIT_W);
          bit_nxt   = BIT_W'(idx32);
          state_nxt = S_FREE;
        end
      end
      S_SCAN: begin
        if (found) begin
          res_paddr_nxt = alloc_paddr;
          if (cnt_r != CNT_MAX) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          state_nxt = S_DONE;
        end else if (wa_r == lastw_r) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          wa_nxt = wa_r + WADDR_W'(1);
        end
      end
      S_FREE: begin
        // Freeing a page that is already free still lowers the count.
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_paddr_nxt  = res_paddr_r;
          out_status_nxt = res_status_r;
          out_cnt_nxt    = cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_valid_r  <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      act_r        <= ACT_ALLOC;
      addr_r       <= '0;
      wa_r         <= '0;
      lastw_r      <= '0;
      tail_r       <= '0;
      bit_r        <= '0;
      rv_q_r       <= 1'b0;
      res_paddr_r  <= '0;
      res_status_r <= ST_DONE;
      out_paddr_r  <= '0;
      out_status_r <= ST_DONE;
      out_cnt_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      row_valid_r  <= row_valid_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      act_r        <= act_nxt;
      addr_r       <= addr_nxt;
      wa_r         <= wa_nxt;
      lastw_r      <= lastw_nxt;
      tail_r       <= tail_nxt;
      bit_r        <= bit_nxt;
      rv_q_r       <= row_valid_r[mem_req.raddr];
      res_paddr_r  <= res_paddr_nxt;
      res_status_r <= res_status_nxt;
      out_paddr_r  <= out_paddr_nxt;
      out_status_r <= out_status_nxt;
      out_cnt_r    <= out_cnt_nxt;
    end
  end

  assign in_if.ready         = (state_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.page_address = out_paddr_r;
  assign out_if.status       = out_status_r;
  assign out_if.pages_in_use = out_cnt_r;

  a_mem_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_SCAN || state_r == S_FREE))
    else $error("bitmap written outside a scan or free step");

  a_fail_no_address: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != ST_DONE) |-> (out_if.page_address == '0))
    else $error("failed request carries a page address");

  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == S_SCAN || state_r == S_FREE) |=> (cnt_r == $past(cnt_r)))
    else $error("used count changed outside an update step");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (wa_r <= lastw_r))
    else $error("scan ran past the last live bitmap word");

endmodule

@@ hw/rtl/bitmap_page_allocator.sv @@
// Top level of the bitmap page allocator: registers, sequencer and bitmap RAM.
// Usage: requests arrive as words on in_if (action 0 allocates the lowest free
// page, action 1 frees the page holding address). Each request yields exactly
// one result word on out_if with page_address, status and pages_in_use.
// The managed range is set over the APB port (base, end, page count); the user
// must do so while no request is in flight, as the block does not enforce it.
// Sequence: a free request passes the check, free and done states before its
// result is loaded into the output register; a rejected free, or an allocation
// with no pages configured, goes from check straight to done. An allocation
// passes check, one scan step per 32-page bitmap word scanned, since the
// sequencer reads one RAM word per cycle, and then done.
// One request is worked on at a time; in_if.ready is high whenever the
// sequencer is free, even while the previous result still waits in the
// output register. When the receiver stalls, the result holds in that
// register and a finished request waits for it before returning to idle.
// Reset clears the registers, the used count and the per-word valid flags,
// so every page reads as free at once; no clearing pass is needed.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bpa_in_if.sink             in_if,
  bpa_out_if.source          out_if,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  cfg_t                 cfg;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] mem_rdata;

  bpa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_if     (in_if),
    .out_if    (out_if),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ test/bitmap_page_allocator_checker.sv @@
// Checker for the bitmap page allocator: tracks the page map and compares each result word.
module bitmap_page_allocator_checker import bpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bpa_in_if                  in_if,
  bpa_out_if                 out_if,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic               cfg_pready,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    status_t           status;
    logic [CNT_W-1:0]  pages_in_use;
  } page_result_t;

  logic [MAX_PAGES-1:0] page_taken;
  logic [CNT_W-1:0]     taken_count;
  logic [ADDR_W-1:0]    base_q;
  logic [ADDR_W-1:0]    last_q;
  logic [PCFG_W-1:0]    pages_q;
  page_result_t         result_q[$];

  initial fail_count = 0;

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Applies one request to the page map and queues the result word it must produce.
  task automatic serve_request(input logic act, input logic [ADDR_W-1:0] addr);
    page_result_t     r;
    int unsigned      live;
    int unsigned      idx;
    logic [63:0]      wide;
    logic [ADDR_W-1:0] offset;
    r = '0;
    r.status = ST_DONE;
    live = (pages_q > MAX_PAGES) ? MAX_PAGES : pages_q;
    if (act == ACT_ALLOC) begin
      idx = 0;
      while (idx < live && page_taken[idx]) idx++;
      if (idx < live) begin
        wide = 64'(base_q) + 64'(idx) * 64'(PAGE_BYTES);
        r.page_address = wide[ADDR_W-1:0];
        page_taken[idx] = 1'b1;
        if (taken_count != CNT_MAX) taken_count++;
      end else begin
        r.status = ST_FULL;
      end
    end else if (addr > last_q || addr < base_q) begin
      r.status = ST_RANGE;
    end else begin
      offset = addr - base_q;
      idx = offset / PAGE_BYTES;
      if (idx >= live) begin
        r.status = ST_RANGE;
      end else begin
        // The bit may already be clear; the count still drops.
        page_taken[idx] = 1'b0;
        if (taken_count != 0) taken_count--;
      end
    end
    r.pages_in_use = taken_count;
    result_q.push_back(r);
  endtask

  always @(posedge clk) begin
    page_result_t want;
    if (!rst_n) begin
      page_taken  = '0;
      taken_count = '0;
      base_q      = '0;
      last_q      = '0;
      pages_q     = '0;
      result_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[PADDR_W-1:2]))
          REG_BASE: begin
            base_q = cfg_pwdata;
          end
          REG_END: begin
            last_q = cfg_pwdata;
          end
          REG_PAGES: begin
            pages_q = cfg_pwdata[PCFG_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result word with no request waiting");
        end else begin
          want = result_q.pop_front();
          if (out_if.page_address !== want.page_address)
            report_mismatch($sformatf("page_address 0x%08h, expected 0x%08h",
                                      out_if.page_address, want.page_address));
          if (out_if.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_if.status, want.status));
          if (out_if.pages_in_use !== want.pages_in_use)
            report_mismatch($sformatf("pages_in_use %0d, expected %0d",
                                      out_if.pages_in_use, want.pages_in_use));
        end
      end
      if (in_if.valid && in_if.ready) serve_request(in_if.action, in_if.address);
    end
    pending <= result_q.size();
  end

  final begin
    if (result_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", result_q.size()));
  end
endmodule

@@ test/bitmap_page_allocator_test.sv @@
// Testbench top of the bitmap page allocator: clock, reset, stimulus and verdict.
module bitmap_page_allocator_test;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic               clk;
  logic               rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;
  int                 fail_count;
  int                 pending;
  int unsigned        quiet_cycles;

  bit                 idle_on = 1'b1;
  bit                 stall_on = 1'b1;
  bit                 hold_req = 1'b0;
  logic [31:0]        cur_base;
  logic [31:0]        cur_end;
  logic [12:0]        cur_pages;

  bpa_in_if  in_ch ();
  bpa_out_if out_ch ();

  bitmap_page_allocator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  bitmap_page_allocator_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request, and steady acceptance at the end.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Offers one request word; valid stays high into the next word unless a gap is drawn.
  task automatic send_word(input logic act, input logic [31:0] addr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.address <= addr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Waits until every outstanding result word has come back and the sequencer is idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] base, input logic [31:0] last,
                           input logic [12:0] pages);
    settle();
    write_reg(REG_BASE, base);
    write_reg(REG_END, last);
    write_reg(REG_PAGES, {19'd0, pages});
    cur_base  = base;
    cur_end   = last;
    cur_pages = pages;
  endtask

  // Mixed allocate and free traffic; most frees aim at pages near the bottom of the range.
  task automatic random_burst(input int unsigned words);
    int unsigned alloc_pct;
    int unsigned live;
    int unsigned span;
    int unsigned pick;
    logic [31:0] addr;
    alloc_pct = $urandom_range(35, 75);
    live = (cur_pages > MAX_PAGES) ? MAX_PAGES : cur_pages;
    span = (live > 60) ? 60 : live + 1;
    repeat (words) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_word(ACT_ALLOC, $urandom);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          addr = cur_base + $urandom_range(0, span) * PAGE_BYTES
                 + $urandom_range(0, PAGE_BYTES - 1);
        end else if (pick == 7) begin
          addr = cur_end + $urandom_range(0, 2) - 1;
        end else begin
          addr = $urandom;
        end
        send_word(ACT_FREE, addr);
      end
    end
  endtask

  initial begin
    logic [31:0] base;
    logic [31:0] last;
    logic [12:0] pages;
    int unsigned sel;
    int unsigned live;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_ALLOC;
    in_ch.address <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    cur_base  = '0;
    cur_end   = '0;
    cur_pages = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the registers at reset there is nothing to hand out and nothing to free.
    send_word(ACT_ALLOC, 32'h0);
    send_word(ACT_FREE, 32'h0);

    base = 32'h1000_0000;
    configure(base, base + 4 * PAGE_BYTES, 13'd4);
    repeat (5) send_word(ACT_ALLOC, $urandom);
    send_word(ACT_FREE, base + 2 * PAGE_BYTES + 123);
    send_word(ACT_FREE, base + 2 * PAGE_BYTES + 123);
    send_word(ACT_ALLOC, 32'hFFFF_FFFF);
    send_word(ACT_FREE, base - 1);
    send_word(ACT_FREE, base + 4 * PAGE_BYTES + 1);
    // The end address itself passes the range check but its index is out of bounds.
    send_word(ACT_FREE, base + 4 * PAGE_BYTES);
    send_word(ACT_FREE, base + 4 * PAGE_BYTES - 1);
    repeat (3) send_word(ACT_FREE, base);
    send_word(ACT_FREE, 32'hFFFF_FFFF);

    // Page counts above the map size are clamped; the second page wraps past 2^32.
    configure(32'hFFFF_F000, 32'hFFFF_FFFF, 13'h1FFF);
    send_word(ACT_ALLOC, 32'h0);
    send_word(ACT_ALLOC, 32'h0);
    send_word(ACT_FREE, 32'hFFFF_FFFF);
    send_word(ACT_FREE, 32'h0);

    // Shrinking the page count keeps the upper bits but hides them.
    configure(32'h0, 32'hFFFF_FFFF, 13'd2);
    send_word(ACT_ALLOC, 32'h0);
    send_word(ACT_ALLOC, 32'h0);
    send_word(ACT_FREE, 2 * PAGE_BYTES);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 0) begin
        configure(32'h0, 32'hFFFF_FFFF, 13'd4096);
      end else begin
        sel = $urandom_range(0, 9);
        case (sel)
          0: begin
            pages = 13'd0;
          end
          1: begin
            pages = 13'd4096;
          end
          2: begin
            pages = 13'h1FFF;
          end
          3: begin
            pages = 13'($urandom_range(4097, 8191));
          end
          default: begin
            pages = 13'($urandom_range(1, 48));
          end
        endcase
        if ($urandom_range(0, 3) == 0) begin
          base = 32'hFFFF_FFFF - $urandom_range(0, 20 * PAGE_BYTES);
        end else begin
          base = $urandom;
        end
        live = (pages > MAX_PAGES) ? MAX_PAGES : pages;
        sel = $urandom_range(0, 4);
        if (sel < 3) begin
          last = base + live * PAGE_BYTES - 1;
        end else if (sel == 3) begin
          last = $urandom;
        end else begin
          last = 32'hFFFF_FFFF;
        end
        configure(base, last, pages);
      end
      // The long receiver hold-off lets the block fill and stall its input.
      if (ph == 1) hold_req = 1'b1;
      if (ph == 6) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      random_burst(88);
    end

    settle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
